[sv/rws_pkg.sv]
// Shared types and constants of the roulette wheel selector.
// Holds the request and result payload structs, the request codes and the
// control state encoding. Depends on nothing.
package rws_pkg;

  localparam int unsigned IndexWidth  = 6;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned RandWidth   = 16;
  localparam int unsigned PopWidth    = 7;

  localparam logic [PopWidth-1:0] PopReset = 7'd64;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [IndexWidth-1:0]  entry_index;
    logic [WeightWidth-1:0] weight_value;
    logic [RandWidth-1:0]   rand_value;
  } req_t;

  typedef struct packed {
    logic [IndexWidth-1:0] selected_index;
    logic                  found;
    logic                  was_selection;
  } res_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

[sv/rws_if.sv]
// Valid/ready stream channel carrying one payload per transfer.
// The payload type is a parameter; the selector uses rws_pkg structs.
interface rws_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/rws_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the weight store of the selector.
module rws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/roulette_wheel_selector.sv]
// Roulette wheel selector. A load transfer reads the old weight at acceptance,
// then writes the new one and updates the total. A select transfer multiplies
// the random value by the total four bits a cycle, then reads the weight RAM
// one entry per cycle for up to n entries, where n is the population count
// capped at MAX_ENTRIES, while a running sum scaled by 2^RAND_BITS - 1 is
// compared against that product, ending early at the first hit. One request is
// in work at a time; the next one is taken once the result has moved to the
// output register. After reset the weight RAM is cleared entry by entry through
// all MAX_ENTRIES entries, during which no request is taken (configuration
// writes are). Depends on rws_pkg, rws_if and rws_ram.
module roulette_wheel_selector #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RAND_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rws_pkg::PopWidth-1:0]  cfg_wdata_i,
  rws_if.sink                           req_i,
  rws_if.source                         res_o
);

  localparam int unsigned IW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NW  = (CW > rws_pkg::PopWidth) ? CW : rws_pkg::PopWidth;
  localparam int unsigned TW  = WEIGHT_BITS + IW;
  localparam int unsigned ND  = (RAND_BITS + 3) / 4;
  localparam int unsigned RP  = ND * 4;
  localparam int unsigned PW  = TW + RP;
  localparam int unsigned DCW = $clog2(ND + 1);
  localparam int unsigned OW  = rws_pkg::IndexWidth;

  rws_pkg::state_e state_q, state_d;

  logic [rws_pkg::PopWidth-1:0] pop_q, pop_d;
  logic [TW-1:0]          total_q, total_d;
  logic [IW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [IW-1:0]          ld_idx_q, ld_idx_d;
  logic [WEIGHT_BITS-1:0] ld_w_q, ld_w_d;
  logic                   ld_ok_q, ld_ok_d;
  logic [RP-1:0]          r_q, r_d;
  logic [DCW-1:0]         dig_cnt_q, dig_cnt_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [CW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                   v1_q, v1_d, v2_q, v2_d;
  logic [IW-1:0]          idx1_q, idx1_d, idx2_q, idx2_d;
  logic [TW-1:0]          cum_q, cum_d;
  rws_pkg::res_t          res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  rws_pkg::res_t          out_q, out_d;

  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;

  logic                   accept, issue, hit, last;
  logic [NW-1:0]          pop_ext, n_eff;
  logic [PW-1:0]          lhs;
  logic [3:0]             digit;

  rws_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == rws_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  assign pop_ext = NW'(pop_q);
  assign n_eff   = (pop_ext > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : pop_ext;
  assign issue   = (state_q == rws_pkg::ST_WALK) && (NW'(rd_cnt_q) < n_eff);
  assign digit   = r_q[RP-1 -: 4];

  // cum * (2^RAND_BITS - 1) without a multiplier.
  assign lhs  = (PW'(cum_q) << RAND_BITS) - PW'(cum_q);
  assign hit  = v2_q && (lhs >= prod_q);
  assign last = (NW'(idx2_q) == n_eff - NW'(1));

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_cnt_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = ld_idx_q;
    ram_wdata = ld_w_q;
    if (accept && (req_i.data.req_type == rws_pkg::REQ_LOAD)) begin
      ram_re    = 1'b1;
      ram_raddr = IW'(req_i.data.entry_index);
    end else if (issue) begin
      ram_re = 1'b1;
    end
    if (state_q == rws_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (state_q == rws_pkg::ST_LOAD) begin
      ram_we = ld_ok_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_d       = cfg_we_i ? cfg_wdata_i : pop_q;
    total_d     = total_q;
    clr_cnt_d   = clr_cnt_q;
    ld_idx_d    = ld_idx_q;
    ld_w_d      = ld_w_q;
    ld_ok_d     = ld_ok_q;
    r_d         = r_q;
    dig_cnt_d   = dig_cnt_q;
    prod_d      = prod_q;
    rd_cnt_d    = rd_cnt_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    idx1_d      = idx1_q;
    idx2_d      = idx2_q;
    cum_d       = cum_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;

    case (state_q)
      rws_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IW'(1);
        if (clr_cnt_q == IW'(MAX_ENTRIES - 1)) begin
          state_d = rws_pkg::ST_IDLE;
        end
      end
      rws_pkg::ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          if (req_i.data.req_type == rws_pkg::REQ_LOAD) begin
            ld_idx_d = IW'(req_i.data.entry_index);
            ld_w_d   = WEIGHT_BITS'(req_i.data.weight_value);
            ld_ok_d  = (32'(req_i.data.entry_index) < 32'(MAX_ENTRIES));
            state_d  = rws_pkg::ST_LOAD;
          end else begin
            res_d.was_selection = 1'b1;
            r_d       = RP'(RAND_BITS'(req_i.data.rand_value));
            dig_cnt_d = '0;
            prod_d    = '0;
            rd_cnt_d  = '0;
            cum_d     = '0;
            if ((total_q == '0) || (n_eff == '0)) begin
              state_d = rws_pkg::ST_DONE;
            end else begin
              state_d = rws_pkg::ST_MUL;
            end
          end
        end
      end
      rws_pkg::ST_LOAD: begin
        // The old weight arrives from the read issued at acceptance.
        if (ld_ok_q) begin
          total_d = total_q - TW'(ram_rdata) + TW'(ld_w_q);
        end
        state_d = rws_pkg::ST_DONE;
      end
      rws_pkg::ST_MUL: begin
        prod_d    = (prod_q << 4) + PW'(total_q) * PW'(digit);
        r_d       = r_q << 4;
        dig_cnt_d = dig_cnt_q + DCW'(1);
        if (dig_cnt_q == DCW'(ND - 1)) begin
          state_d = rws_pkg::ST_WALK;
        end
      end
      rws_pkg::ST_WALK: begin
        v1_d   = issue;
        idx1_d = rd_cnt_q[IW-1:0];
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
        end
        v2_d   = v1_q;
        idx2_d = idx1_q;
        if (v1_q) begin
          cum_d = cum_q + TW'(ram_rdata);
        end
        if (hit) begin
          res_d.found          = 1'b1;
          res_d.selected_index = OW'(idx2_q);
          v1_d    = 1'b0;
          v2_d    = 1'b0;
          state_d = rws_pkg::ST_DONE;
        end else if (v2_q && last) begin
          v1_d    = 1'b0;
          v2_d    = 1'b0;
          state_d = rws_pkg::ST_DONE;
        end
      end
      rws_pkg::ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = rws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rws_pkg::ST_CLEAR;
      pop_q       <= rws_pkg::PopReset;
      total_q     <= '0;
      clr_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pop_q       <= pop_d;
      total_q     <= total_d;
      clr_cnt_q   <= clr_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_idx_q <= ld_idx_d;
    ld_w_q   <= ld_w_d;
    ld_ok_q  <= ld_ok_d;
    r_q      <= r_d;
    prod_q   <= prod_d;
    idx1_q   <= idx1_d;
    idx2_q   <= idx2_d;
    cum_q    <= cum_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  a_load_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.was_selection) |->
      (!res_o.data.found && (res_o.data.selected_index == '0)))
    else $error("load acknowledge carries a selection");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rws_pkg::ST_WALK) |-> !ram_we)
    else $error("weight RAM written during a walk");

  a_prod_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rws_pkg::ST_WALK) && ($past(state_q) == rws_pkg::ST_WALK)) |->
      $stable(prod_q))
    else $error("product changed during a walk");

  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> (state_q == rws_pkg::ST_WALK))
    else $error("walk pipeline active outside a walk");

endmodule
